// ===== rtl/core/scm_pkg.sv =====
// Shared types, opcodes and constants of the stack calculator machine.
package scm_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_GREGS   = 4;
    localparam int WORD_W      = 32;
    localparam int CMD_W       = 4;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_W     = 5;
    localparam int GIDX_W      = 2;
    localparam int DIV_STEPS   = WORD_W;

    typedef enum logic [CMD_W-1:0] {
        OP_EXIT      = 4'd0,
        OP_PUSH      = 4'd1,
        OP_POP       = 4'd2,
        OP_ADD       = 4'd3,
        OP_SUB       = 4'd4,
        OP_MUL       = 4'd5,
        OP_DIV       = 4'd6,
        OP_PEEK      = 4'd7,
        OP_PUSH_GREG = 4'd8,
        OP_POPR      = 4'd9
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_BADOP     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_WB
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic commit;
    } scm_cmd_t;

    typedef struct packed {
        logic div_go;
        logic div_done;
    } scm_stat_t;

endpackage

// ===== rtl/core/stack_calculator_machine_top.sv =====
// Top level of the stack calculator machine.
// Each input transaction is one instruction and yields exactly one result
// transaction with status, value and the stack depth after it. Most
// instructions pass through accept, execute and write back before the next
// is accepted; a divide with a nonzero divisor also waits in a divide state
// on the radix-2 divider, which retires one quotient bit per cycle. The
// stack lives in a memory with registered reads, so operands are fetched in
// the accept cycle. A finished result sits in an output register, and the
// next instruction is accepted while it waits; the next write back stalls
// only if that result has still not been taken.
module stack_calculator_machine_top #(
    parameter int STACK_DEPTH = scm_pkg::STACK_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [scm_pkg::CMD_W-1:0]           s_cmd,
    input  logic signed [scm_pkg::WORD_W-1:0]   s_immediate,
    input  logic [scm_pkg::GIDX_W-1:0]          s_reg_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [scm_pkg::STATUS_W-1:0]        m_status,
    output logic signed [scm_pkg::WORD_W-1:0]   m_value,
    output logic                                m_value_valid,
    output logic [scm_pkg::DEPTH_W-1:0]         m_depth
);

    scm_pkg::scm_cmd_t  cmd;
    scm_pkg::scm_stat_t st;

    scm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    scm_dp #(
        .DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .s_cmd         (s_cmd),
        .s_immediate   (s_immediate),
        .s_reg_index   (s_reg_index),
        .m_status      (m_status),
        .m_value       (m_value),
        .m_value_valid (m_value_valid),
        .m_depth       (m_depth)
    );

endmodule

// ===== rtl/core/scm_div.sv =====
// Radix-2 signed divider, truncating toward zero, one quotient bit per cycle.
module scm_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [scm_pkg::WORD_W-1:0]       dividend,
    input  logic [scm_pkg::WORD_W-1:0]       divisor,
    output logic                             done,
    output logic [scm_pkg::WORD_W-1:0]       quotient
);

    localparam int W    = scm_pkg::WORD_W;
    localparam int CNTW = $clog2(scm_pkg::DIV_STEPS);

    logic            running_reg, running_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    q_reg;
    logic [W-1:0]    d_reg;
    logic            neg_reg;

    logic [W-1:0]    a_abs, b_abs;
    logic [W:0]      rem_sh, trial;

    assign a_abs  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
    assign b_abs  = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;
    assign rem_sh = {rem_reg, q_reg[W-1]};
    assign trial  = rem_sh - {1'b0, d_reg};

    always_comb begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        if (start) begin
            running_next = 1'b1;
            cnt_next     = '0;
        end else if (running_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(scm_pkg::DIV_STEPS - 1)) begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    // remainder stays below the divisor magnitude, so W bits hold it
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= a_abs;
            d_reg   <= b_abs;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end else if (running_reg) begin
            if (!trial[W]) begin
                rem_reg <= trial[W-1:0];
                q_reg   <= {q_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[W-1:0];
                q_reg   <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

// ===== rtl/core/scm_ctrl.sv =====
// Controller state machine: sequences accept, execute, divide and write back.
module scm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  scm_pkg::scm_stat_t  st,
    output scm_pkg::scm_cmd_t   cmd
);

    scm_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scm_pkg::S_IDLE: begin
                if (s_valid) state_next = scm_pkg::S_EXEC;
            end
            scm_pkg::S_EXEC: begin
                state_next = st.div_go ? scm_pkg::S_DIV : scm_pkg::S_WB;
            end
            scm_pkg::S_DIV: begin
                if (st.div_done) state_next = scm_pkg::S_WB;
            end
            scm_pkg::S_WB: begin
                if (slot_free) state_next = scm_pkg::S_IDLE;
            end
            default: state_next = scm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.exec      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            scm_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            scm_pkg::S_EXEC: begin
                cmd.exec      = 1'b1;
                cmd.div_start = st.div_go;
            end
            scm_pkg::S_DIV: begin
            end
            scm_pkg::S_WB: begin
                cmd.commit = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scm_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/scm_dp.sv =====
// Datapath: stack memory, general registers, ALU, divider and result register.
module scm_dp #(
    parameter int DEPTH = scm_pkg::STACK_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  scm_pkg::scm_cmd_t                   cmd,
    output scm_pkg::scm_stat_t                  st,
    input  logic [scm_pkg::CMD_W-1:0]           s_cmd,
    input  logic signed [scm_pkg::WORD_W-1:0]   s_immediate,
    input  logic [scm_pkg::GIDX_W-1:0]          s_reg_index,
    output logic [scm_pkg::STATUS_W-1:0]        m_status,
    output logic signed [scm_pkg::WORD_W-1:0]   m_value,
    output logic                                m_value_valid,
    output logic [scm_pkg::DEPTH_W-1:0]         m_depth
);

    localparam int W  = scm_pkg::WORD_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]                 mem [DEPTH];
    logic [W-1:0]                 gregs_reg [scm_pkg::NUM_GREGS];
    logic [CW-1:0]                count_reg;

    logic [scm_pkg::CMD_W-1:0]    op_reg;
    logic [W-1:0]                 imm_reg;
    logic [scm_pkg::GIDX_W-1:0]   ri_reg;
    logic [W-1:0]                 top_reg, nxt_reg;

    scm_pkg::status_t             res_status, res_status_reg;
    logic [W-1:0]                 res_value, res_value_reg;
    logic                         res_valid, res_valid_reg;
    logic                         wr_en, wr_en_reg;
    logic [AW-1:0]                wr_addr, wr_addr_reg;
    logic [W-1:0]                 wr_data, wr_data_reg;
    logic [CW-1:0]                cnt_next, cnt_next_reg;
    logic                         greg_we, greg_we_reg;
    logic                         div_req;

    logic [scm_pkg::STATUS_W-1:0] out_status_reg;
    logic [W-1:0]                 out_value_reg;
    logic                         out_valid_reg;
    logic [scm_pkg::DEPTH_W-1:0]  out_depth_reg;

    logic [AW-1:0]                rd_top_addr, rd_nxt_addr;
    logic                         full, empty, short;
    logic [W-1:0]                 alu_res;
    logic                         div_done;
    logic [W-1:0]                 div_q;

    assign rd_top_addr = AW'(count_reg - 1'b1);
    assign rd_nxt_addr = AW'(count_reg - CW'(2));
    assign full        = (count_reg == CW'(DEPTH));
    assign empty       = (count_reg == '0);
    assign short       = (count_reg < CW'(2));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_cmd;
            imm_reg <= s_immediate;
            ri_reg  <= s_reg_index;
            top_reg <= mem[rd_top_addr];
            nxt_reg <= mem[rd_nxt_addr];
        end
        if (cmd.commit && wr_en_reg) begin
            mem[wr_addr_reg] <= wr_data_reg;
        end
    end

    always_comb begin
        unique case (op_reg)
            scm_pkg::OP_ADD: alu_res = nxt_reg + top_reg;
            scm_pkg::OP_SUB: alu_res = nxt_reg - top_reg;
            scm_pkg::OP_MUL: alu_res = nxt_reg * top_reg;
            default:         alu_res = '0;
        endcase
    end

    always_comb begin
        res_status = scm_pkg::ST_OK;
        res_value  = '0;
        res_valid  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = AW'(count_reg);
        wr_data    = imm_reg;
        cnt_next   = count_reg;
        greg_we    = 1'b0;
        div_req    = 1'b0;
        unique case (op_reg)
            scm_pkg::OP_EXIT: begin
                cnt_next = '0;
            end
            scm_pkg::OP_PUSH, scm_pkg::OP_PUSH_GREG: begin
                if (full) begin
                    res_status = scm_pkg::ST_OVERFLOW;
                end else begin
                    wr_en    = 1'b1;
                    wr_data  = (op_reg == scm_pkg::OP_PUSH) ? imm_reg : gregs_reg[ri_reg];
                    cnt_next = count_reg + 1'b1;
                end
            end
            scm_pkg::OP_POP, scm_pkg::OP_POPR: begin
                if (empty) begin
                    res_status = scm_pkg::ST_UNDERFLOW;
                end else begin
                    res_value = top_reg;
                    res_valid = 1'b1;
                    cnt_next  = count_reg - 1'b1;
                    greg_we   = (op_reg == scm_pkg::OP_POPR);
                end
            end
            scm_pkg::OP_ADD, scm_pkg::OP_SUB, scm_pkg::OP_MUL, scm_pkg::OP_DIV: begin
                if (short) begin
                    res_status = scm_pkg::ST_UNDERFLOW;
                end else if (op_reg == scm_pkg::OP_DIV && top_reg == '0) begin
                    res_status = scm_pkg::ST_DIVZERO;
                end else begin
                    res_value = alu_res;
                    res_valid = 1'b1;
                    wr_en     = 1'b1;
                    wr_addr   = rd_nxt_addr;
                    wr_data   = alu_res;
                    cnt_next  = count_reg - 1'b1;
                    div_req   = (op_reg == scm_pkg::OP_DIV);
                end
            end
            scm_pkg::OP_PEEK: begin
                if (!empty) begin
                    res_value = top_reg;
                    res_valid = 1'b1;
                end
            end
            default: begin
                res_status = scm_pkg::ST_BADOP;
            end
        endcase
    end

    scm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (nxt_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign st = {div_req, div_done};

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg <= res_status;
            res_value_reg  <= res_value;
            res_valid_reg  <= res_valid;
            wr_en_reg      <= wr_en;
            wr_addr_reg    <= wr_addr;
            wr_data_reg    <= wr_data;
            cnt_next_reg   <= cnt_next;
            greg_we_reg    <= greg_we;
        end else if (div_done) begin
            res_value_reg <= div_q;
            wr_data_reg   <= div_q;
        end
        if (cmd.commit) begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_valid_reg  <= res_valid_reg;
            out_depth_reg  <= scm_pkg::DEPTH_W'(cnt_next_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < scm_pkg::NUM_GREGS; i++) begin
                gregs_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            count_reg <= cnt_next_reg;
            if (greg_we_reg) begin
                gregs_reg[ri_reg] <= res_value_reg;
            end
        end
    end

    assign m_status      = out_status_reg;
    assign m_value       = out_value_reg;
    assign m_value_valid = out_valid_reg;
    assign m_depth       = out_depth_reg;

endmodule

// ===== rtl/core/scm_checker.sv =====
// Port-level assertions for the stack calculator machine, bound to the top level.
module scm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [scm_pkg::STATUS_W-1:0]        m_status,
    input logic signed [scm_pkg::WORD_W-1:0]   m_value,
    input logic                                m_value_valid
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while one is in progress");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_value) && $stable(m_status)))
        else $error("stalled result changed or dropped");

    a_no_value_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != scm_pkg::ST_OK) |-> !m_value_valid)
        else $error("value flagged valid on an error status");

    a_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_value_valid) |-> (m_value == '0))
        else $error("nonzero value without value_valid");

endmodule

bind stack_calculator_machine_top scm_checker u_scm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_value       (m_value),
    .m_value_valid (m_value_valid)
);
